>>> hdl/banked_mmu_address_translator_defines.svh
// Assertion macros shared by the banked MMU address translator RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef BANKED_MMU_ADDRESS_TRANSLATOR_DEFINES_SVH
`define BANKED_MMU_ADDRESS_TRANSLATOR_DEFINES_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define BMMU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bmmu assertion failed");

// The condition must never be true at a clock edge outside reset.
`define BMMU_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bmmu forbidden condition seen");

`else

`define BMMU_ASSERT(lbl, clk, rst_n, prop)
`define BMMU_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

>>> hdl/bmmu_pkg.sv
// Types, codes and size tables shared by the banked MMU address translator.
// No dependencies.
`timescale 1ns / 1ps

package bmmu_pkg;

  // Result target codes.
  typedef enum logic [2:0] {
    TGT_RAM  = 3'd0,
    TGT_IROM = 3'd1,
    TGT_CROM = 3'd2,
    TGT_IO   = 3'd3,
    TGT_DROP = 3'd4,
    TGT_REG  = 3'd5
  } target_e;

  // Input operation codes.
  typedef enum logic {
    OP_ACCESS  = 1'b0,
    OP_BANK_WR = 1'b1
  } op_e;

  // Classification that the front end hands to the back end.
  typedef enum logic [1:0] {
    KIND_PAGE = 2'd0,
    KIND_IO   = 2'd1,
    KIND_VEC  = 2'd2,
    KIND_REG  = 2'd3
  } kind_e;

  // ROM layout codes.
  typedef enum logic [1:0] {
    ROM_MAP_SPLIT_A = 2'd0,
    ROM_MAP_SPLIT_B = 2'd1,
    ROM_MAP_INT32   = 2'd2,
    ROM_MAP_CART32  = 2'd3
  } rom_map_e;

  // Configuration register indexes (byte address is four times the index).
  typedef enum logic [2:0] {
    REG_RAM_SIZE    = 3'd0,
    REG_MMU_ENABLE  = 3'd1,
    REG_MMU_TASK    = 3'd2,
    REG_RAM_VECTORS = 3'd3,
    REG_ROM_MAP     = 3'd4,
    REG_MAP_TYPE    = 3'd5,
    REG_MMU_PREFIX  = 3'd6,
    REG_UNUSED      = 3'd7
  } reg_idx_e;

  localparam logic [15:0] IO_BASE     = 16'hFF00;
  localparam logic [15:0] VECTOR_BASE = 16'hFE00;
  localparam int unsigned OFS_W       = 13;
  localparam int unsigned PAGE_W      = 10;
  localparam int unsigned SIZE_W      = 6;
  localparam logic [1:0]  RAM_SIZE_RST = 2'd1;

  typedef struct packed {
    logic [1:0] ram_size;
    logic       mmu_enable;
    logic       mmu_task;
    logic       ram_vectors;
    logic [1:0] rom_map;
    logic       map_type;
    logic [1:0] mmu_prefix;
  } cfg_t;

  typedef struct packed {
    kind_e               kind;
    logic [PAGE_W-1:0]   page;
    logic [15:0]         address;
    logic                is_write;
    logic [7:0]          wdata;
  } entry_t;

  function automatic logic [PAGE_W-1:0] size_mask(input logic [1:0] sz);
    logic [PAGE_W-1:0] m;
    case (sz)
      2'd0:    m = 10'd15;
      2'd1:    m = 10'd63;
      2'd2:    m = 10'd255;
      default: m = 10'd1023;
    endcase
    return m;
  endfunction

  function automatic logic [SIZE_W-1:0] fixed_base(input logic [1:0] sz);
    logic [SIZE_W-1:0] b;
    case (sz)
      2'd0:    b = 6'd8;
      default: b = 6'd56;
    endcase
    return b;
  endfunction

  function automatic logic [SIZE_W-1:0] top_page(input logic [1:0] sz);
    logic [SIZE_W-1:0] t;
    case (sz)
      2'd0:    t = 6'd15;
      default: t = 6'd63;
    endcase
    return t;
  endfunction

  function automatic logic [SIZE_W-1:0] low_page(input logic [1:0] sz);
    logic [SIZE_W-1:0] l;
    case (sz)
      2'd0:    l = 6'd12;
      default: l = 6'd60;
    endcase
    return l;
  endfunction

endpackage

>>> hdl/bmmu_front.sv
// Front end: accepts transactions, holds the bank register table and classifies
// each transaction into a queue entry. Depends on bmmu_pkg.
`timescale 1ns / 1ps

module bmmu_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bmmu_pkg::cfg_t       cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 op_i,
  input  logic [15:0]          address_i,
  input  logic                 is_write_i,
  input  logic [3:0]           reg_index_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 full_i,
  output logic                 push_o,
  output bmmu_pkg::entry_t     entry_o
);

  logic [bmmu_pkg::PAGE_W-1:0] bank_q [16];
  logic [3:0]                  rd_idx;
  logic [bmmu_pkg::PAGE_W-1:0] mask;
  logic [bmmu_pkg::PAGE_W-1:0] bank_wr_val;
  logic                        bank_wr;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;
  assign mask       = bmmu_pkg::size_mask(cfg_i.ram_size);
  assign bank_wr_val = {cfg_i.mmu_prefix, data_byte_i & mask[7:0]};
  assign bank_wr    = push_o && (op_i == bmmu_pkg::OP_BANK_WR);
  assign rd_idx     = {cfg_i.mmu_task, address_i[15:13]};

  // Bank registers reset to the fixed page map of the default RAM size.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        bank_q[i] <= bmmu_pkg::PAGE_W'(i % 8)
                     + bmmu_pkg::PAGE_W'(bmmu_pkg::fixed_base(bmmu_pkg::RAM_SIZE_RST));
      end
    end else if (bank_wr) begin
      bank_q[reg_index_i] <= bank_wr_val;
    end
  end

  always_comb begin
    entry_o.address  = address_i;
    entry_o.is_write = is_write_i;
    entry_o.wdata    = is_write_i ? data_byte_i : 8'd0;
    if (cfg_i.mmu_enable) begin
      entry_o.page = bank_q[rd_idx];
    end else begin
      entry_o.page = bmmu_pkg::PAGE_W'({3'd0, address_i[15:13]})
                     + bmmu_pkg::PAGE_W'(bmmu_pkg::fixed_base(cfg_i.ram_size));
    end
    if (op_i == bmmu_pkg::OP_BANK_WR) begin
      entry_o.kind = bmmu_pkg::KIND_REG;
    end else if (address_i >= bmmu_pkg::IO_BASE) begin
      entry_o.kind = bmmu_pkg::KIND_IO;
    end else if (address_i >= bmmu_pkg::VECTOR_BASE && cfg_i.ram_vectors) begin
      entry_o.kind = bmmu_pkg::KIND_VEC;
    end else begin
      entry_o.kind = bmmu_pkg::KIND_PAGE;
    end
  end

endmodule

>>> hdl/bmmu_queue.sv
// Small first-in first-out queue of classified entries between front and back end.
// Depends on bmmu_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "banked_mmu_address_translator_defines.svh"

module bmmu_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bmmu_pkg::entry_t  entry_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              pop_i,
  output bmmu_pkg::entry_t  entry_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  bmmu_pkg::entry_t  mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  `BMMU_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o)
  `BMMU_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && !valid_o)
  `BMMU_ASSERT(a_cnt_bounded, clk_i, rst_ni, cnt_q <= CNT_W'(DEPTH))
  `BMMU_ASSERT(a_ptr_gap, clk_i, rst_ni,
    (cnt_q == '0 || cnt_q == CNT_W'(DEPTH)) |-> (wr_ptr_q == rd_ptr_q))

endmodule

>>> hdl/bmmu_back.sv
// Back end: resolves the ROM window, builds the physical address and holds the
// result in the output register. Depends on bmmu_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "banked_mmu_address_translator_defines.svh"

module bmmu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bmmu_pkg::cfg_t    cfg_i,
  input  logic              q_valid_i,
  input  bmmu_pkg::entry_t  q_entry_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        target_o,
  output logic [22:0]       phys_addr_o,
  output logic [7:0]        write_data_o
);

  logic                        out_valid_q;
  bmmu_pkg::target_e           target_q, target_d;
  logic [22:0]                 phys_q, phys_d;
  logic [7:0]                  wdata_q, wdata_d;

  logic [bmmu_pkg::PAGE_W-1:0] page;
  logic [bmmu_pkg::PAGE_W-1:0] lo;
  logic [bmmu_pkg::PAGE_W-1:0] hi;
  logic [bmmu_pkg::PAGE_W-1:0] slot_full;
  logic [1:0]                  slot;
  logic [bmmu_pkg::OFS_W-1:0]  ofs;
  logic                        rom_hit;

  assign page      = q_entry_i.page;
  assign ofs       = q_entry_i.address[bmmu_pkg::OFS_W-1:0];
  assign lo        = bmmu_pkg::PAGE_W'(bmmu_pkg::low_page(cfg_i.ram_size));
  assign hi        = bmmu_pkg::PAGE_W'(bmmu_pkg::top_page(cfg_i.ram_size));
  assign slot_full = page - lo;
  assign slot      = slot_full[1:0];
  assign rom_hit   = !cfg_i.map_type && (page >= lo) && (page <= hi);

  always_comb begin
    target_d = bmmu_pkg::TGT_RAM;
    phys_d   = '0;
    wdata_d  = '0;
    case (q_entry_i.kind)
      bmmu_pkg::KIND_REG: begin
        target_d = bmmu_pkg::TGT_REG;
      end
      bmmu_pkg::KIND_IO: begin
        target_d = bmmu_pkg::TGT_IO;
        phys_d   = {7'd0, q_entry_i.address};
        wdata_d  = q_entry_i.wdata;
      end
      bmmu_pkg::KIND_VEC: begin
        target_d = bmmu_pkg::TGT_RAM;
        phys_d   = {hi, ofs};
        wdata_d  = q_entry_i.wdata;
      end
      default: begin
        if (!rom_hit) begin
          target_d = bmmu_pkg::TGT_RAM;
          phys_d   = {page & bmmu_pkg::size_mask(cfg_i.ram_size), ofs};
          wdata_d  = q_entry_i.wdata;
        end else if (q_entry_i.is_write) begin
          target_d = bmmu_pkg::TGT_DROP;
        end else if (cfg_i.rom_map == bmmu_pkg::ROM_MAP_INT32) begin
          target_d = bmmu_pkg::TGT_IROM;
          phys_d   = {8'd0, slot, ofs};
        end else if (slot[1]) begin
          // Outside the internal 32K layout, the upper two ROM pages map to the bottom of the cartridge.
          target_d = bmmu_pkg::TGT_CROM;
          phys_d   = {8'd0, 1'b0, slot[0], ofs};
        end else if (cfg_i.rom_map == bmmu_pkg::ROM_MAP_CART32) begin
          target_d = bmmu_pkg::TGT_CROM;
          phys_d   = {8'd0, 1'b1, slot[0], ofs};
        end else begin
          target_d = bmmu_pkg::TGT_IROM;
          phys_d   = {8'd0, slot, ofs};
        end
      end
    endcase
  end

  assign pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      target_q <= target_d;
      phys_q   <= phys_d;
      wdata_q  <= wdata_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign target_o     = target_q;
  assign phys_addr_o  = phys_q;
  assign write_data_o = wdata_q;

  `BMMU_ASSERT(a_drop_clean, clk_i, rst_ni,
    (out_valid_q && target_q == bmmu_pkg::TGT_DROP) |-> (phys_q == '0 && wdata_q == '0))
  `BMMU_ASSERT(a_rom_no_data, clk_i, rst_ni,
    (out_valid_q && (target_q == bmmu_pkg::TGT_IROM || target_q == bmmu_pkg::TGT_CROM))
    |-> (wdata_q == '0 && phys_q[22:15] == '0))
  `BMMU_ASSERT(a_reg_clean, clk_i, rst_ni,
    (out_valid_q && target_q == bmmu_pkg::TGT_REG) |-> (phys_q == '0 && wdata_q == '0))
  `BMMU_ASSERT(a_hold_on_stall, clk_i, rst_ni,
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(phys_q) && $stable(wdata_q)))

endmodule

>>> hdl/banked_mmu_address_translator.sv
// Banked MMU address translator top level: configuration registers, APB-style port,
// and the front end, entry queue and back end. Depends on bmmu_pkg and the bmmu modules.
`timescale 1ns / 1ps

// Translates one CPU byte access or bank register write per transaction into a
// target (RAM, internal ROM, cartridge ROM, I/O, dropped write, register
// written), a 23-bit physical address and the write byte. The block sustains one
// transaction per clock cycle when nothing stalls: the front end looks up the bank
// register table in the cycle a transaction is accepted and writes a classified
// entry into a short queue, and the back end takes the entry from the queue,
// resolves the ROM window and loads the output register, which presents the result
// until it is taken with out_stall_i low. The queue lets input acceptance
// continue while a finished result waits on out_stall_i; in_stall_o rises only
// once the queue (QUEUE_DEPTH entries) is full. Bank register writes take effect
// for the very next transaction. Configuration registers sit at byte addresses
// 0, 4, ..., 24 and must only be written while no transaction is in flight.
// There is no clearing pass after reset: the sixteen bank registers reset
// directly to the fixed page map of the default 512K RAM size.

module banked_mmu_address_translator #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [15:0] address_i,
  input  logic        is_write_i,
  input  logic [3:0]  reg_index_i,
  input  logic [7:0]  data_byte_i,
  // Output channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  target_o,
  output logic [22:0] phys_addr_o,
  output logic [7:0]  write_data_o
);

  bmmu_pkg::cfg_t     cfg_q;
  bmmu_pkg::reg_idx_e reg_idx;
  logic               cfg_wr;

  logic               push;
  logic               full;
  logic               q_valid;
  logic               pop;
  bmmu_pkg::entry_t   push_entry;
  bmmu_pkg::entry_t   pop_entry;

  // The port never inserts wait states.
  assign pready  = 1'b1;
  assign reg_idx = bmmu_pkg::reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Each register keeps only its own width of the written value; writes to the
  // unused address are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ram_size    <= bmmu_pkg::RAM_SIZE_RST;
      cfg_q.mmu_enable  <= 1'b0;
      cfg_q.mmu_task    <= 1'b0;
      cfg_q.ram_vectors <= 1'b0;
      cfg_q.rom_map     <= 2'd0;
      cfg_q.map_type    <= 1'b0;
      cfg_q.mmu_prefix  <= 2'd0;
    end else if (cfg_wr) begin
      case (reg_idx)
        bmmu_pkg::REG_RAM_SIZE:    cfg_q.ram_size    <= pwdata[1:0];
        bmmu_pkg::REG_MMU_ENABLE:  cfg_q.mmu_enable  <= pwdata[0];
        bmmu_pkg::REG_MMU_TASK:    cfg_q.mmu_task    <= pwdata[0];
        bmmu_pkg::REG_RAM_VECTORS: cfg_q.ram_vectors <= pwdata[0];
        bmmu_pkg::REG_ROM_MAP:     cfg_q.rom_map     <= pwdata[1:0];
        bmmu_pkg::REG_MAP_TYPE:    cfg_q.map_type    <= pwdata[0];
        bmmu_pkg::REG_MMU_PREFIX:  cfg_q.mmu_prefix  <= pwdata[1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bmmu_pkg::REG_RAM_SIZE:    prdata = {30'd0, cfg_q.ram_size};
      bmmu_pkg::REG_MMU_ENABLE:  prdata = {31'd0, cfg_q.mmu_enable};
      bmmu_pkg::REG_MMU_TASK:    prdata = {31'd0, cfg_q.mmu_task};
      bmmu_pkg::REG_RAM_VECTORS: prdata = {31'd0, cfg_q.ram_vectors};
      bmmu_pkg::REG_ROM_MAP:     prdata = {30'd0, cfg_q.rom_map};
      bmmu_pkg::REG_MAP_TYPE:    prdata = {31'd0, cfg_q.map_type};
      bmmu_pkg::REG_MMU_PREFIX:  prdata = {30'd0, cfg_q.mmu_prefix};
      default:                   prdata = 32'd0;
    endcase
  end

  // Front end: accepts a transaction whenever the queue has room, updates the
  // bank registers on register writes and picks the page for accesses.
  bmmu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .address_i   (address_i),
    .is_write_i  (is_write_i),
    .reg_index_i (reg_index_i),
    .data_byte_i (data_byte_i),
    .full_i      (full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  bmmu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .entry_o (pop_entry)
  );

  // Back end: decodes the ROM window and drives the registered result.
  bmmu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_valid_i    (q_valid),
    .q_entry_i    (pop_entry),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .target_o     (target_o),
    .phys_addr_o  (phys_addr_o),
    .write_data_o (write_data_o)
  );

endmodule

>>> tb/sv/tb_banked_mmu_address_translator.sv
// Self-checking testbench for the banked MMU address translator: a directed table, then
// random phases under several register settings. Depends on bmmu_pkg and the block's top.
`timescale 1ns / 1ps

module tb_banked_mmu_address_translator;

  // Generous ceiling on the run.
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned DIR_ROWS       = 34;
  localparam int unsigned RANDOM_PHASES  = 9;
  localparam int unsigned ITEMS_PER_PHASE = 92;

  // One row of the directed table is either a transaction or a register write.
  typedef enum logic {
    ROW_TXN = 1'b0,
    ROW_CFG = 1'b1
  } row_kind_e;

  // Receiver behavior: free flow, a solid stall, or a stall chopped at random.
  typedef enum logic [1:0] {
    RX_FLOW = 2'd0,
    RX_HOLD = 2'd1,
    RX_CHOP = 2'd2
  } rx_mode_e;

  typedef struct packed {
    bmmu_pkg::op_e op;
    logic [15:0]   addr;
    logic          wr;
    logic [3:0]    ri;
    logic [7:0]    data;
  } bus_item_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [22:0] phys;
    logic [7:0]  wdata;
  } result_t;

  // Transaction rows carry REG_UNUSED in cfg_idx; it has no meaning there. A row with
  // has_fixed set carries its expected result inline instead of using the predictor.
  typedef struct packed {
    row_kind_e          kind;
    bmmu_pkg::reg_idx_e cfg_idx;
    logic [1:0]         cfg_val;
    bmmu_pkg::op_e      op;
    logic [15:0]        addr;
    logic               wr;
    logic [3:0]         ri;
    logic [7:0]         data;
    logic               has_fixed;
    logic [2:0]         f_target;
    logic [22:0]        f_phys;
    logic [7:0]         f_wdata;
  } dir_row_t;

  // Every input of the block holds a known value from time zero.
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [4:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        op_i        = 1'b0;
  logic [15:0] address_i   = '0;
  logic        is_write_i  = 1'b0;
  logic [3:0]  reg_index_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  target_o;
  logic [22:0] phys_addr_o;
  logic [7:0]  write_data_o;

  // Inline expectation that travels with the payload of a directed row.
  logic        fixed_pending = 1'b0;
  result_t     fixed_result  = '0;

  // Predictor state: our own copy of the registers and of the sixteen bank registers.
  bmmu_pkg::cfg_t mmu_cfg;
  logic [9:0]  bank_pages [16];
  result_t     translations_due [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned burst_left     = 0;
  int unsigned rx_left        = 0;
  rx_mode_e    rx_mode        = RX_FLOW;
  dir_row_t    directed_rows [DIR_ROWS];

  banked_mmu_address_translator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .address_i    (address_i),
    .is_write_i   (is_write_i),
    .reg_index_i  (reg_index_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .target_o     (target_o),
    .phys_addr_o  (phys_addr_o),
    .write_data_o (write_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Computes the result of one accepted transaction and applies any bank register write
  // to the predictor's table, so that the next transaction already sees it.
  function automatic result_t translate_txn(input bus_item_t it);
    result_t     r;
    logic [9:0]  mask;
    logic [9:0]  base;
    logic [9:0]  lo;
    logic [9:0]  hi;
    logic [9:0]  page;
    logic [9:0]  slot;
    logic [12:0] ofs;
    logic [7:0]  wd;
    r   = '0;
    ofs = it.addr[12:0];
    wd  = it.wr ? it.data : 8'h00;
    case (mmu_cfg.ram_size)
      2'd0: begin
        mask = 10'd15;  base = 10'd8;  lo = 10'd12; hi = 10'd15;
      end
      2'd1: begin
        mask = 10'd63;  base = 10'd56; lo = 10'd60; hi = 10'd63;
      end
      2'd2: begin
        mask = 10'd255; base = 10'd56; lo = 10'd60; hi = 10'd63;
      end
      default: begin
        mask = 10'd1023; base = 10'd56; lo = 10'd60; hi = 10'd63;
      end
    endcase
    if (it.op == bmmu_pkg::OP_BANK_WR) begin
      bank_pages[it.ri] = {mmu_cfg.mmu_prefix, it.data & mask[7:0]};
      r.target = bmmu_pkg::TGT_REG;
    end else if (it.addr >= bmmu_pkg::IO_BASE) begin
      r.target = bmmu_pkg::TGT_IO;
      r.phys   = {7'd0, it.addr};
      r.wdata  = wd;
    end else if (it.addr >= bmmu_pkg::VECTOR_BASE && mmu_cfg.ram_vectors) begin
      r.target = bmmu_pkg::TGT_RAM;
      r.phys   = {hi, ofs};
      r.wdata  = wd;
    end else begin
      if (mmu_cfg.mmu_enable) begin
        page = bank_pages[{mmu_cfg.mmu_task, it.addr[15:13]}];
      end else begin
        page = base + {7'd0, it.addr[15:13]};
      end
      // Prefixed pages sit far above the top page, so they never land in the ROM window.
      if (!mmu_cfg.map_type && page >= lo && page <= hi) begin
        slot = page - lo;
        if (it.wr) begin
          r.target = bmmu_pkg::TGT_DROP;
        end else if (mmu_cfg.rom_map == bmmu_pkg::ROM_MAP_INT32) begin
          r.target = bmmu_pkg::TGT_IROM;
          r.phys   = {slot, ofs};
        end else if (slot >= 10'd2) begin
          r.target = bmmu_pkg::TGT_CROM;
          r.phys   = {slot - 10'd2, ofs};
        end else if (mmu_cfg.rom_map == bmmu_pkg::ROM_MAP_CART32) begin
          // The lower two ROM pages reach the upper half of the cartridge image.
          r.target = bmmu_pkg::TGT_CROM;
          r.phys   = {slot + 10'd2, ofs};
        end else begin
          r.target = bmmu_pkg::TGT_IROM;
          r.phys   = {slot, ofs};
        end
      end else begin
        r.target = bmmu_pkg::TGT_RAM;
        r.phys   = {page & mask, ofs};
        r.wdata  = wd;
      end
    end
    return r;
  endfunction

  // Random transaction. Most are accesses; the address is steered toward the I/O page, the
  // vector page and the edges of a bank, and bank writes often aim at a ROM page.
  function automatic bus_item_t random_item();
    bus_item_t it;
    logic [7:0] rom_lo;
    it.op   = ($urandom_range(0, 4) == 0) ? bmmu_pkg::OP_BANK_WR : bmmu_pkg::OP_ACCESS;
    it.wr   = 1'($urandom());
    it.ri   = 4'($urandom());
    it.data = 8'($urandom());
    case ($urandom_range(0, 9))
      0:       it.addr = {8'hFF, 8'($urandom())};
      1:       it.addr = {8'hFE, 8'($urandom())};
      2:       it.addr = {3'($urandom()), ($urandom_range(0, 1) ? 13'h1FFF : 13'h0000)};
      default: it.addr = 16'($urandom());
    endcase
    rom_lo = (mmu_cfg.ram_size == 2'd0) ? 8'd12 : 8'd60;
    if (it.op == bmmu_pkg::OP_BANK_WR && $urandom_range(0, 2) == 0) begin
      it.data = rom_lo + 8'($urandom_range(0, 3));
    end
    return it;
  endfunction

  // Register write over the configuration port: a setup phase, an access phase that
  // completes once pready is high, then a return to idle. Only the low two bits of the
  // data matter; the rest are random. The predictor copy is updated after the write.
  task automatic write_reg(input bmmu_pkg::reg_idx_e idx, input logic [1:0] val);
    logic [31:0] word;
    word = {30'($urandom()), val};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      bmmu_pkg::REG_RAM_SIZE:    mmu_cfg.ram_size    = word[1:0];
      bmmu_pkg::REG_MMU_ENABLE:  mmu_cfg.mmu_enable  = word[0];
      bmmu_pkg::REG_MMU_TASK:    mmu_cfg.mmu_task    = word[0];
      bmmu_pkg::REG_RAM_VECTORS: mmu_cfg.ram_vectors = word[0];
      bmmu_pkg::REG_ROM_MAP:     mmu_cfg.rom_map     = word[1:0];
      bmmu_pkg::REG_MAP_TYPE:    mmu_cfg.map_type    = word[0];
      bmmu_pkg::REG_MMU_PREFIX:  mmu_cfg.mmu_prefix  = word[1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Presents one transaction and holds it until the block takes it.
  task automatic send_item(input bus_item_t it, input logic has_fixed, input result_t fixed);
    in_valid_i    <= 1'b1;
    op_i          <= it.op;
    address_i     <= it.addr;
    is_write_i    <= it.wr;
    reg_index_i   <= it.ri;
    data_byte_i   <= it.data;
    fixed_pending <= has_fixed;
    fixed_result  <= fixed;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Sender pacing: bursts of random length, separated by random gaps. A zero gap keeps
  // valid high straight into the next burst, which gives stretches with no idling.
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Stops sending and waits until every expected result has arrived and the two-stage
  // pipeline has drained, so that the block is idle for a register write.
  task automatic go_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (translations_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Receiver: switches between free flow, solid stalls and chopped stalls.
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 12) : $urandom_range(4, 40);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_FLOW: out_stall_i <= 1'b0;
      RX_HOLD: out_stall_i <= 1'b1;
      default: out_stall_i <= 1'($urandom());
    endcase
  end

  // Scoreboard. The output side is checked first, then an accepted input transaction is
  // predicted and queued; both look at the values that stood just before the edge.
  always @(posedge clk_i) begin : scoreboard
    result_t   got;
    result_t   want;
    result_t   pred;
    bus_item_t it;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {target_o, phys_addr_o, write_data_o};
        if (translations_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected result: target %0d phys %06h data %02h",
                     got.target, got.phys, got.wdata);
          end
        end else begin
          want = translations_due.pop_front();
          if (got.target !== want.target || got.phys !== want.phys ||
              got.wdata !== want.wdata) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("result mismatch: expected target %0d phys %06h data %02h, got %0d %06h %02h",
                       want.target, want.phys, want.wdata, got.target, got.phys, got.wdata);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        it   = {bmmu_pkg::op_e'(op_i), address_i, is_write_i, reg_index_i, data_byte_i};
        pred = translate_txn(it);
        translations_due.push_back(fixed_pending ? fixed_result : pred);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t           row;
    bus_item_t          it;
    result_t            fixed;
    bmmu_pkg::reg_idx_e idx;
    logic [1:0]         val;

    // Register and bank table state right after reset: the bank registers hold the fixed
    // page map of the default 512K size, bank number within the task plus 56.
    mmu_cfg          = '0;
    mmu_cfg.ram_size = bmmu_pkg::RAM_SIZE_RST;
    for (int i = 0; i < 16; i++) begin
      bank_pages[i] = 10'd56 + 10'(i % 8);
    end

    // Directed table. Expected results are typed in for the reset map, the I/O page, a
    // dropped ROM write, a ROM read at the window base and bank register writes.
    directed_rows = '{
      '{ROW_TXN, bmmu_pkg::REG_UNUSED, 0, bmmu_pkg::OP_ACCESS, 16'h0000, 0, 0, 8'h00,
        1, bmmu_pkg::TGT_RAM, 23'h070000, 0},
      '{ROW_TXN, bmmu_pkg::REG_UNUSED, 0, bmmu_pkg::OP_ACCESS, 16'h1FFF, 1, 0, 8'hFF,
        1, bmmu_pkg::TGT_RAM, 23'h071FFF, 8'hFF},
      '{ROW_TXN, bmmu_pkg::REG_UNUSED, 0, bmmu_pkg::OP_ACCESS, 16'hFFFF, 0, 0, 8'h5A,
        1, bmmu_pkg::TGT_IO, 23'h00FFFF, 0},
      '{ROW_TXN, bmmu_pkg::REG_UNUSED, 0, bmmu_pkg::OP_ACCESS, 16'hFF00, 1, 0, 8'hA5,
        1, bmmu_pkg::TGT_IO, 23'h00FF00, 8'hA5},
      '{ROW_TXN, bmmu_pkg::REG_UNUSED, 0, bmmu_pkg::OP_ACCESS, 16'hFE10, 0, 0, 8'h00,
        0, bmmu_pkg::TGT_RAM, 0, 0},
      '{ROW_TXN, bmmu_pkg::REG_UNUSED, 0, bmmu_pkg::OP_ACCESS, 16'h8000, 1, 0, 8'h55,
        1, bmmu_pkg::TGT_DROP, 23'h000000, 0},
      '{ROW_TXN, bmmu_pkg::REG_UNUSED, 0, bmmu_pkg::OP_ACCESS, 16'h8000, 0, 0, 8'h00,
        1, bmmu_pkg::TGT_IROM, 23'h000000, 0},
      '{ROW_TXN, bmmu_pkg::REG_UNUSED, 0, bmmu_pkg::OP_ACCESS, 16'hA123, 0, 0, 8'h00,
        0, bmmu_pkg::TGT_RAM, 0, 0},
      '{ROW_TXN, bmmu_pkg::REG_UNUSED, 0, bmmu_pkg::OP_ACCESS, 16'hDFFF, 0, 0, 8'h00,
        0, bmmu_pkg::TGT_RAM, 0, 0},
      '{ROW_TXN, bmmu_pkg::REG_UNUSED, 0, bmmu_pkg::OP_ACCESS, 16'hFDFF, 0, 0, 8'h00,
        0, bmmu_pkg::TGT_RAM, 0, 0},
      '{ROW_TXN, bmmu_pkg::REG_UNUSED, 0, bmmu_pkg::OP_BANK_WR, 16'h0000, 0, 4'h0, 8'hFF,
        1, bmmu_pkg::TGT_REG, 0, 0},
      '{ROW_TXN, bmmu_pkg::REG_UNUSED, 0, bmmu_pkg::OP_BANK_WR, 16'hFFFF, 1, 4'hF, 8'h00,
        1, bmmu_pkg::TGT_REG, 0, 0},
      '{ROW_TXN, bmmu_pkg::REG_UNUSED, 0, bmmu_pkg::OP_BANK_WR, 16'h0000, 0, 4'h8, 8'h3C,
        1, bmmu_pkg::TGT_REG, 0, 0},
      '{ROW_CFG, bmmu_pkg::REG_MMU_ENABLE, 1, bmmu_pkg::OP_ACCESS, 16'h0000, 0, 0, 8'h00,
        0, bmmu_pkg::TGT_RAM, 0, 0},
      '{ROW_TXN, bmmu_pkg::REG_UNUSED, 0, bmmu_pkg::OP_ACCESS, 16'h0010, 0, 0, 8'h00,
        0, bmmu_pkg::TGT_RAM, 0, 0},
      '{ROW_CFG, bmmu_pkg::REG_MMU_TASK, 1, bmmu_pkg::OP_ACCESS, 16'h0000, 0, 0, 8'h00,
        0, bmmu_pkg::TGT_RAM, 0, 0},
      '{ROW_TXN, bmmu_pkg::REG_UNUSED, 0, bmmu_pkg::OP_ACCESS, 16'h1234, 0, 0, 8'h00,
        0, bmmu_pkg::TGT_RAM, 0, 0},
      '{ROW_TXN, bmmu_pkg::REG_UNUSED, 0, bmmu_pkg::OP_ACCESS, 16'hE000, 1, 0, 8'h81,
        0, bmmu_pkg::TGT_RAM, 0, 0},
      '{ROW_CFG, bmmu_pkg::REG_ROM_MAP, 3, bmmu_pkg::OP_ACCESS, 16'h0000, 0, 0, 8'h00,
        0, bmmu_pkg::TGT_RAM, 0, 0},
      '{ROW_TXN, bmmu_pkg::REG_UNUSED, 0, bmmu_pkg::OP_ACCESS, 16'h0000, 0, 0, 8'h00,
        0, bmmu_pkg::TGT_RAM, 0, 0},
      '{ROW_CFG, bmmu_pkg::REG_RAM_VECTORS, 1, bmmu_pkg::OP_ACCESS, 16'h0000, 0, 0, 8'h00,
        0, bmmu_pkg::TGT_RAM, 0, 0},
      '{ROW_TXN, bmmu_pkg::REG_UNUSED, 0, bmmu_pkg::OP_ACCESS, 16'hFE00, 0, 0, 8'h00,
        0, bmmu_pkg::TGT_RAM, 0, 0},
      '{ROW_TXN, bmmu_pkg::REG_UNUSED, 0, bmmu_pkg::OP_ACCESS, 16'hFEFF, 1, 0, 8'h3C,
        0, bmmu_pkg::TGT_RAM, 0, 0},
      '{ROW_CFG, bmmu_pkg::REG_MMU_PREFIX, 3, bmmu_pkg::OP_ACCESS, 16'h0000, 0, 0, 8'h00,
        0, bmmu_pkg::TGT_RAM, 0, 0},
      '{ROW_TXN, bmmu_pkg::REG_UNUSED, 0, bmmu_pkg::OP_BANK_WR, 16'h0000, 1, 4'h9, 8'hFF,
        1, bmmu_pkg::TGT_REG, 0, 0},
      '{ROW_TXN, bmmu_pkg::REG_UNUSED, 0, bmmu_pkg::OP_ACCESS, 16'h3FFF, 0, 0, 8'h00,
        0, bmmu_pkg::TGT_RAM, 0, 0},
      '{ROW_CFG, bmmu_pkg::REG_MMU_ENABLE, 0, bmmu_pkg::OP_ACCESS, 16'h0000, 0, 0, 8'h00,
        0, bmmu_pkg::TGT_RAM, 0, 0},
      '{ROW_CFG, bmmu_pkg::REG_RAM_SIZE, 0, bmmu_pkg::OP_ACCESS, 16'h0000, 0, 0, 8'h00,
        0, bmmu_pkg::TGT_RAM, 0, 0},
      '{ROW_TXN, bmmu_pkg::REG_UNUSED, 0, bmmu_pkg::OP_ACCESS, 16'h8000, 0, 0, 8'h00,
        0, bmmu_pkg::TGT_RAM, 0, 0},
      '{ROW_TXN, bmmu_pkg::REG_UNUSED, 0, bmmu_pkg::OP_ACCESS, 16'h2000, 0, 0, 8'h00,
        0, bmmu_pkg::TGT_RAM, 0, 0},
      '{ROW_CFG, bmmu_pkg::REG_MAP_TYPE, 1, bmmu_pkg::OP_ACCESS, 16'h0000, 0, 0, 8'h00,
        0, bmmu_pkg::TGT_RAM, 0, 0},
      '{ROW_TXN, bmmu_pkg::REG_UNUSED, 0, bmmu_pkg::OP_ACCESS, 16'h8000, 1, 0, 8'h77,
        0, bmmu_pkg::TGT_RAM, 0, 0},
      '{ROW_CFG, bmmu_pkg::REG_UNUSED, 3, bmmu_pkg::OP_ACCESS, 16'h0000, 0, 0, 8'h00,
        0, bmmu_pkg::TGT_RAM, 0, 0},
      '{ROW_TXN, bmmu_pkg::REG_UNUSED, 0, bmmu_pkg::OP_ACCESS, 16'hFE80, 0, 0, 8'h00,
        0, bmmu_pkg::TGT_RAM, 0, 0}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Register rows first let the block drain.
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        go_idle();
        write_reg(row.cfg_idx, row.cfg_val);
      end else begin
        it    = {row.op, row.addr, row.wr, row.ri, row.data};
        fixed = {row.f_target, row.f_phys, row.f_wdata};
        send_item(it, row.has_fixed, fixed);
        pace();
      end
    end

    // Random phases. The first uses every register at its low end and the second at its
    // high end; the rest walk the RAM sizes and ROM layouts with the other fields random.
    // Each phase starts from an idle block, which also covers a sender pause with
    // nothing left in flight.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      go_idle();
      for (int r = 0; r < 8; r++) begin
        idx = bmmu_pkg::reg_idx_e'(r);
        if (p == 0) begin
          val = 2'd0;
        end else if (p == 1) begin
          val = 2'd3;
        end else begin
          case (idx)
            bmmu_pkg::REG_RAM_SIZE:   val = 2'((p + 1) % 4);
            bmmu_pkg::REG_ROM_MAP:    val = 2'(p % 4);
            bmmu_pkg::REG_MMU_ENABLE: val = {1'($urandom()), 1'($urandom_range(0, 9) < 7)};
            bmmu_pkg::REG_MAP_TYPE:   val = {1'($urandom()), 1'($urandom_range(0, 3) == 0)};
            bmmu_pkg::REG_MMU_PREFIX: val = $urandom_range(0, 1) ? 2'd0 : 2'($urandom());
            default:                  val = 2'($urandom());
          endcase
        end
        write_reg(idx, val);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        it    = random_item();
        fixed = '0;
        send_item(it, 1'b0, fixed);
        pace();
      end
    end

    go_idle();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && translations_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> banked_mmu_address_translator.f
+incdir+hdl
hdl/bmmu_pkg.sv
hdl/bmmu_front.sv
hdl/bmmu_queue.sv
hdl/bmmu_back.sv
hdl/banked_mmu_address_translator.sv
tb/sv/tb_banked_mmu_address_translator.sv
